@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// concurrent checks, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next cycle check failed");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ design/lmal_pkg.sv @@
// ----------------------------------------------------------------------------
// lmal_pkg
// shared constants, operation codes and control structs of the locator
// ----------------------------------------------------------------------------
package lmal_pkg;

    localparam int unsigned POS_W       = 13;
    localparam int unsigned ST_W        = 2;
    localparam int unsigned CI_W        = 5;
    localparam int unsigned CMD_MAX_LEN = 16;

    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_OBRACE = 8'd123;
    localparam logic [7:0] CH_CBRACE = 8'd125;
    localparam logic [7:0] CH_OBRK = 8'd91;
    localparam logic [7:0] CH_CBRK = 8'd93;

    localparam logic [ST_W-1:0] ST_CLOSED   = 2'd0;
    localparam logic [ST_W-1:0] ST_UNCLOSED = 2'd1;
    localparam logic [ST_W-1:0] ST_NONE     = 2'd2;
    localparam logic [ST_W-1:0] ST_OVERFLOW = 2'd3;

    localparam logic [1:0] REG_CMD_LO  = 2'd0;
    localparam logic [1:0] REG_CMD_HI  = 2'd1;
    localparam logic [1:0] REG_CMD_LEN = 2'd2;
    localparam logic [1:0] REG_CMD_LIM = 2'd3;

    localparam logic [1:0] K_HOLD    = 2'd0;
    localparam logic [1:0] K_FROM_I  = 2'd1;
    localparam logic [1:0] K_INC     = 2'd2;
    localparam logic [1:0] K_FROM_IC = 2'd3;

    localparam logic [1:0] REL_HOLD  = 2'd0;
    localparam logic [1:0] REL_CLR   = 2'd1;
    localparam logic [1:0] REL_ONE   = 2'd2;
    localparam logic [1:0] REL_TRACK = 2'd3;

    localparam logic [1:0] ROPT_HOLD = 2'd0;
    localparam logic [1:0] ROPT_ONE  = 2'd1;
    localparam logic [1:0] ROPT_INC  = 2'd2;
    localparam logic [1:0] ROPT_DEC  = 2'd3;

    localparam logic [1:0] OUT_SPAN = 2'd0;
    localparam logic [1:0] OUT_PEND = 2'd1;
    localparam logic [1:0] OUT_OVF  = 2'd2;
    localparam logic [1:0] OUT_NONE = 2'd3;

    typedef struct packed {
        logic       load;
        logic       i_clr;
        logic       i_inc;
        logic [1:0] k_op;
        logic       ci_one;
        logic       ci_inc;
        logic [1:0] rel_op;
        logic [1:0] ropt_op;
        logic       opener_set;
        logic       span_wr;
        logic       pend_set;
        logic       ovf_set;
        logic       s_clr;
        logic       s_inc;
        logic       out_load;
        logic [1:0] out_kind;
        logic       doc_clr;
    } t_cmd;

    typedef struct packed {
        logic is_blank;
        logic is_obrace;
        logic is_obrk;
        logic is_cbrk;
        logic sc_close;
        logic m0;
        logic mci;
        logic i_done;
        logic ci_done;
        logic ic_end;
        logic k_lt_last;
        logic k_ge_n;
        logic rel_nz;
        logic ropt_nz;
        logic cnt_ge_lim;
        logic cnt_zero;
        logic has_pend;
        logic ovf;
        logic s_lt_cnt;
        logic out_free;
    } t_stat;

endpackage

@@ design/latex_mandatory_argument_locator.sv @@
// ----------------------------------------------------------------------------
// latex_mandatory_argument_locator: finds mandatory argument spans of a command
// loading takes one character per cycle; the last character starts the search
// search: all characters (command, blank, bracket, argument) share the single
// text memory read port and are examined one at a time
// results: one by one, held on output stall; one request in flight at a time
// synchronous reset sets control and config to defaults; text store is not cleared
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module latex_mandatory_argument_locator import lmal_pkg::*; #(
    parameter int MAX_TEXT     = 4096,
    parameter int MAX_COMMANDS = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [7:0]       i_char_code,
    input  logic             i_last_char,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [POS_W-1:0] o_opener_pos,
    output logic [POS_W-1:0] o_closer_pos,
    output logic [ST_W-1:0]  o_status,
    output logic             o_last_result,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [1:0]       i_cfg_index,
    input  logic [63:0]      i_cfg_data
);

    t_cmd  s_cmd;
    t_stat s_stat;

    assign o_cfg_ready = 1'b1;

    lmal_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_last_char (i_last_char),
        .o_in_stall  (o_in_stall),
        .i_stat      (s_stat),
        .o_cmd       (s_cmd)
    );

    lmal_dp #(
        .MAX_TEXT     (MAX_TEXT),
        .MAX_COMMANDS (MAX_COMMANDS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (s_cmd),
        .o_stat        (s_stat),
        .i_char_code   (i_char_code),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_opener_pos  (o_opener_pos),
        .o_closer_pos  (o_closer_pos),
        .o_status      (o_status),
        .o_last_result (o_last_result)
    );

    `ASSERT_IMPL(a_load_free, i_clk, i_rst_n, s_cmd.out_load, s_stat.out_free)
    `ASSERT_IMPL(a_idle_no_out, i_clk, i_rst_n, !o_in_stall, !s_cmd.out_load)
    `ASSERT_IMPL(a_span_room, i_clk, i_rst_n, s_cmd.span_wr, !s_stat.cnt_ge_lim)
    `ASSERT_NEXT(a_done_idle, i_clk, i_rst_n, s_cmd.doc_clr, !o_in_stall)

endmodule

@@ design/lmal_dp.sv @@
// ----------------------------------------------------------------------------
// lmal_dp
// datapath: text store, scan pointers, span store, config and output register
// ----------------------------------------------------------------------------
module lmal_dp import lmal_pkg::*; #(
    parameter int MAX_TEXT     = 4096,
    parameter int MAX_COMMANDS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_stat             o_stat,
    input  logic [7:0]        i_char_code,
    input  logic              i_cfg_valid,
    input  logic [1:0]        i_cfg_index,
    input  logic [63:0]       i_cfg_data,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output logic [POS_W-1:0]  o_opener_pos,
    output logic [POS_W-1:0]  o_closer_pos,
    output logic [ST_W-1:0]   o_status,
    output logic              o_last_result
);

    localparam int AW = (MAX_TEXT > 1) ? $clog2(MAX_TEXT) : 1;
    localparam int LW = $clog2(MAX_TEXT + 1);
    localparam int SW = (MAX_COMMANDS > 1) ? $clog2(MAX_COMMANDS) : 1;
    localparam int CW = $clog2(MAX_COMMANDS + 1);

    logic [7:0]      r_text [MAX_TEXT];
    logic [2*LW-1:0] r_spans [MAX_COMMANDS];

    logic [LW-1:0]   r_len, r_i, r_k, r_rel, r_ropt, r_opener, r_pend;
    logic [CI_W-1:0] r_ci;
    logic [CW-1:0]   r_cnt, r_s;
    logic            r_has_pend, r_ovf;
    logic [7:0]      r_rd;
    logic [2*LW-1:0] r_sp_rd;
    logic [63:0]     r_cmd_lo, r_cmd_hi;
    logic [4:0]      r_cmd_len;
    logic [6:0]      r_cmd_lim;
    logic            r_ov;

    logic [7:0]      cmd_bytes [CMD_MAX_LEN];
    logic [4:0]      len_eff;
    logic [6:0]      lim_eff;
    logic [LW-1:0]   k_plus;
    logic            text_room;

    for (genvar j = 0; j < 8; j++) begin : g_bytes
        assign cmd_bytes[j]     = r_cmd_lo[8*j +: 8];
        assign cmd_bytes[j + 8] = r_cmd_hi[8*j +: 8];
    end

    assign len_eff = (r_cmd_len == 5'd0) ? 5'd1 :
                     (r_cmd_len > 5'(CMD_MAX_LEN)) ? 5'(CMD_MAX_LEN) : r_cmd_len;
    assign lim_eff = (r_cmd_lim > 7'(MAX_COMMANDS)) ? 7'(MAX_COMMANDS) : r_cmd_lim;
    assign k_plus    = r_k + LW'(1);
    assign text_room = r_len < LW'(MAX_TEXT);

    always_comb begin
        o_stat            = '0;
        o_stat.is_blank   = (r_rd == CH_SPACE) || (r_rd == 8'd0);
        o_stat.is_obrace  = r_rd == CH_OBRACE;
        o_stat.is_obrk    = r_rd == CH_OBRK;
        o_stat.is_cbrk    = r_rd == CH_CBRK;
        o_stat.sc_close   = (r_rd == CH_CBRACE) && (r_rel == LW'(1));
        o_stat.m0         = r_rd == cmd_bytes[0];
        o_stat.mci        = r_rd == cmd_bytes[r_ci[3:0]];
        o_stat.i_done     = r_i >= r_len;
        o_stat.ci_done    = r_ci >= len_eff;
        o_stat.ic_end     = ((LW+1)'(r_i) + (LW+1)'(r_ci)) >= (LW+1)'(r_len);
        o_stat.k_lt_last  = ((LW+1)'(r_k) + (LW+1)'(1)) < (LW+1)'(r_len);
        o_stat.k_ge_n     = r_k >= r_len;
        o_stat.rel_nz     = r_rel != '0;
        o_stat.ropt_nz    = r_ropt != '0;
        o_stat.cnt_ge_lim = 8'(r_cnt) >= 8'(lim_eff);
        o_stat.cnt_zero   = r_cnt == '0;
        o_stat.has_pend   = r_has_pend;
        o_stat.ovf        = r_ovf;
        o_stat.s_lt_cnt   = r_s < r_cnt;
        o_stat.out_free   = !r_ov || !i_out_stall;
    end

    // stores
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && text_room) begin
            r_text[r_len[AW-1:0]] <= i_char_code;
        end
        r_rd <= r_text[r_k[AW-1:0]];
        if (i_cmd.span_wr) begin
            r_spans[r_cnt[SW-1:0]] <= {r_opener, k_plus};
        end
        r_sp_rd <= r_spans[r_s[SW-1:0]];
    end

    // control and config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len      <= '0;
            r_cnt      <= '0;
            r_has_pend <= 1'b0;
            r_ovf      <= 1'b0;
            r_ov       <= 1'b0;
            r_cmd_lo   <= '0;
            r_cmd_hi   <= '0;
            r_cmd_len  <= 5'd1;
            r_cmd_lim  <= 7'd64;
        end else begin
            if (i_cmd.load && text_room) begin
                r_len <= r_len + LW'(1);
            end
            if (i_cmd.span_wr) begin
                r_cnt      <= r_cnt + CW'(1);
                r_has_pend <= 1'b0;
            end
            if (i_cmd.pend_set) begin
                r_has_pend <= 1'b1;
            end
            if (i_cmd.ovf_set) begin
                r_ovf <= 1'b1;
            end
            if (i_cmd.doc_clr) begin
                r_len      <= '0;
                r_cnt      <= '0;
                r_has_pend <= 1'b0;
                r_ovf      <= 1'b0;
            end
            if (i_cmd.out_load) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_CMD_LO:  r_cmd_lo  <= i_cfg_data;
                    REG_CMD_HI:  r_cmd_hi  <= i_cfg_data;
                    REG_CMD_LEN: r_cmd_len <= i_cfg_data[4:0];
                    REG_CMD_LIM: r_cmd_lim <= i_cfg_data[6:0];
                    default:     r_cmd_lim <= r_cmd_lim;
                endcase
            end
        end
    end

    // scan registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.i_clr) begin
            r_i <= '0;
        end else if (i_cmd.i_inc) begin
            r_i <= r_i + LW'(1);
        end
        case (i_cmd.k_op)
            K_FROM_I:  r_k <= r_i;
            K_INC:     r_k <= k_plus;
            K_FROM_IC: r_k <= LW'(r_i + LW'(r_ci));
            default:   r_k <= r_k;
        endcase
        if (i_cmd.ci_one) begin
            r_ci <= CI_W'(1);
        end else if (i_cmd.ci_inc) begin
            r_ci <= r_ci + CI_W'(1);
        end
        case (i_cmd.rel_op)
            REL_CLR: r_rel <= '0;
            REL_ONE: r_rel <= LW'(1);
            REL_TRACK: begin
                if (r_rd == CH_OBRACE) begin
                    r_rel <= r_rel + LW'(1);
                end else if (r_rd == CH_CBRACE) begin
                    r_rel <= r_rel - LW'(1);
                end
            end
            default: r_rel <= r_rel;
        endcase
        case (i_cmd.ropt_op)
            ROPT_ONE: r_ropt <= LW'(1);
            ROPT_INC: r_ropt <= r_ropt + LW'(1);
            ROPT_DEC: r_ropt <= r_ropt - LW'(1);
            default:  r_ropt <= r_ropt;
        endcase
        if (i_cmd.opener_set) begin
            r_opener <= k_plus;
        end
        if (i_cmd.pend_set) begin
            r_pend <= r_opener;
        end
        if (i_cmd.s_clr) begin
            r_s <= '0;
        end else if (i_cmd.s_inc) begin
            r_s <= r_s + CW'(1);
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            case (i_cmd.out_kind)
                OUT_SPAN: begin
                    o_opener_pos  <= POS_W'(r_sp_rd[2*LW-1:LW]);
                    o_closer_pos  <= POS_W'(r_sp_rd[LW-1:0]);
                    o_status      <= ST_CLOSED;
                    o_last_result <= !r_has_pend && ((r_s + CW'(1)) == r_cnt);
                end
                OUT_PEND: begin
                    o_opener_pos  <= POS_W'(r_pend);
                    o_closer_pos  <= '0;
                    o_status      <= ST_UNCLOSED;
                    o_last_result <= 1'b1;
                end
                OUT_OVF: begin
                    o_opener_pos  <= '0;
                    o_closer_pos  <= '0;
                    o_status      <= ST_OVERFLOW;
                    o_last_result <= 1'b1;
                end
                default: begin
                    o_opener_pos  <= '0;
                    o_closer_pos  <= '0;
                    o_status      <= ST_NONE;
                    o_last_result <= 1'b1;
                end
            endcase
        end
    end

    assign o_out_valid = r_ov;

endmodule

@@ design/lmal_ctrl.sv @@
// ----------------------------------------------------------------------------
// lmal_ctrl
// sequencer: load, command match, argument search and result emission
// ----------------------------------------------------------------------------
module lmal_ctrl import lmal_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_last_char,
    output logic  o_in_stall,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_START  = 5'd1;
    localparam logic [4:0] S_M0RD   = 5'd2;
    localparam logic [4:0] S_M0     = 5'd3;
    localparam logic [4:0] S_MCHK   = 5'd4;
    localparam logic [4:0] S_MRD    = 5'd5;
    localparam logic [4:0] S_MCMP   = 5'd6;
    localparam logic [4:0] S_SKIP   = 5'd7;
    localparam logic [4:0] S_SKRD   = 5'd8;
    localparam logic [4:0] S_SKEV   = 5'd9;
    localparam logic [4:0] S_BR     = 5'd10;
    localparam logic [4:0] S_BRRD   = 5'd11;
    localparam logic [4:0] S_BREV   = 5'd12;
    localparam logic [4:0] S_BRC    = 5'd13;
    localparam logic [4:0] S_BRCRD  = 5'd14;
    localparam logic [4:0] S_BRCEV  = 5'd15;
    localparam logic [4:0] S_POSTBR = 5'd16;
    localparam logic [4:0] S_CHK    = 5'd17;
    localparam logic [4:0] S_SCRD   = 5'd18;
    localparam logic [4:0] S_SC     = 5'd19;
    localparam logic [4:0] S_NEXT   = 5'd20;
    localparam logic [4:0] S_OUT    = 5'd21;
    localparam logic [4:0] S_ORD    = 5'd22;
    localparam logic [4:0] S_OEM    = 5'd23;
    localparam logic [4:0] S_DONE   = 5'd24;

    logic [4:0] r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = r_state != S_IDLE;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_last_char) begin
                        o_cmd.i_clr = 1'b1;
                        n_state     = S_START;
                    end
                end
            end
            S_START: begin
                if (i_stat.i_done) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.k_op = K_FROM_I;
                    n_state    = S_M0RD;
                end
            end
            S_M0RD: n_state = S_M0;
            S_M0: begin
                if (i_stat.m0) begin
                    o_cmd.ci_one = 1'b1;
                    o_cmd.rel_op = REL_CLR;
                    n_state      = S_MCHK;
                end else begin
                    n_state = S_NEXT;
                end
            end
            S_MCHK: begin
                if (i_stat.ci_done) begin
                    n_state = S_SKIP;
                end else if (i_stat.ic_end) begin
                    n_state = S_NEXT;
                end else begin
                    o_cmd.k_op = K_FROM_IC;
                    n_state    = S_MRD;
                end
            end
            S_MRD: n_state = S_MCMP;
            S_MCMP: begin
                if (i_stat.mci) begin
                    o_cmd.ci_inc = 1'b1;
                    n_state      = S_MCHK;
                end else begin
                    n_state = S_NEXT;
                end
            end
            S_SKIP: begin
                if (i_stat.k_lt_last) begin
                    o_cmd.k_op = K_INC;
                    n_state    = S_SKRD;
                end else if (i_stat.cnt_ge_lim) begin
                    o_cmd.ovf_set = 1'b1;
                    n_state       = S_OUT;
                end else begin
                    n_state = S_NEXT;
                end
            end
            S_SKRD: n_state = S_SKEV;
            S_SKEV: begin
                if (i_stat.is_blank) begin
                    n_state = S_SKIP;
                end else if (i_stat.is_obrk) begin
                    o_cmd.ropt_op = ROPT_ONE;
                    n_state       = S_BR;
                end else begin
                    n_state = S_CHK;
                end
            end
            S_BR: begin
                o_cmd.k_op = K_INC;
                if (i_stat.ropt_nz && i_stat.k_lt_last) begin
                    n_state = S_BRRD;
                end else begin
                    n_state = S_POSTBR;
                end
            end
            S_BRRD: n_state = S_BREV;
            S_BREV: begin
                n_state = S_BR;
                if (i_stat.is_cbrk) begin
                    o_cmd.ropt_op = ROPT_DEC;
                end else if (i_stat.is_obrace) begin
                    o_cmd.rel_op = REL_ONE;
                    n_state      = S_BRC;
                end else if (i_stat.is_obrk) begin
                    o_cmd.ropt_op = ROPT_INC;
                end
            end
            S_BRC: begin
                if (i_stat.rel_nz && i_stat.k_lt_last) begin
                    o_cmd.k_op = K_INC;
                    n_state    = S_BRCRD;
                end else begin
                    n_state = S_BR;
                end
            end
            S_BRCRD: n_state = S_BRCEV;
            S_BRCEV: begin
                o_cmd.rel_op = REL_TRACK;
                n_state      = S_BRC;
            end
            S_POSTBR: n_state = i_stat.k_ge_n ? S_NEXT : S_CHK;
            S_CHK: begin
                if (i_stat.is_obrace) begin
                    if (i_stat.cnt_ge_lim) begin
                        o_cmd.ovf_set = 1'b1;
                        n_state       = S_OUT;
                    end else begin
                        o_cmd.opener_set = 1'b1;
                        o_cmd.rel_op     = REL_CLR;
                        n_state          = S_SC;
                    end
                end else if (i_stat.is_blank) begin
                    n_state = S_SKIP;
                end else begin
                    n_state = S_NEXT;
                end
            end
            S_SCRD: n_state = S_SC;
            S_SC: begin
                o_cmd.rel_op = REL_TRACK;
                if (i_stat.sc_close) begin
                    o_cmd.span_wr = 1'b1;
                    n_state       = S_NEXT;
                end else if (i_stat.k_lt_last) begin
                    o_cmd.k_op = K_INC;
                    n_state    = S_SCRD;
                end else begin
                    o_cmd.pend_set = 1'b1;
                    n_state        = S_NEXT;
                end
            end
            S_NEXT: begin
                o_cmd.i_inc = 1'b1;
                n_state     = S_START;
            end
            S_OUT: begin
                if (i_stat.ovf || (i_stat.cnt_zero && !i_stat.has_pend)) begin
                    if (i_stat.out_free) begin
                        o_cmd.out_load = 1'b1;
                        o_cmd.out_kind = i_stat.ovf ? OUT_OVF : OUT_NONE;
                        n_state        = S_DONE;
                    end
                end else begin
                    o_cmd.s_clr = 1'b1;
                    n_state     = S_ORD;
                end
            end
            S_ORD: n_state = S_OEM;
            S_OEM: begin
                if (i_stat.s_lt_cnt) begin
                    if (i_stat.out_free) begin
                        o_cmd.out_load = 1'b1;
                        o_cmd.out_kind = OUT_SPAN;
                        o_cmd.s_inc    = 1'b1;
                        n_state        = S_ORD;
                    end
                end else if (!i_stat.has_pend) begin
                    n_state = S_DONE;
                end else if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_kind = OUT_PEND;
                    n_state        = S_DONE;
                end
            end
            S_DONE: begin
                o_cmd.doc_clr = 1'b1;
                n_state       = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule
